// ===== rtl/mpct_pkg.sv =====
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 1;
    localparam int MOUSE_BYTE_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

    // header bit positions
    localparam int HDR_SYNC_IDX = 3;
    localparam int HDR_LEFT_IDX = 0;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } phase_t;

endpackage

// ===== rtl/mouse_packet_cursor_tracker.sv =====
// Top level: mouse byte stream to clamped cursor position and left button state.
//
//  channel | dir | bits                                   | beat
//  s_      | in  | tdata[7:0] data_byte                    | one mouse byte
//  m_      | out | tdata x[CB-1:0], y, left, zero padding  | one completed packet
//  cfg_    | in  | addr 0 screen_width, 1 screen_height    | one register write
//
//  One byte is taken per cycle unless stalled; a result is registered the cycle after byte 3.
//  Header and x bytes are always taken; the third byte waits only while a result is unsent.
//  aresetn (synchronous) returns to header phase, position 0,0 and a 1024x768 screen.
//  A header byte with bit 3 clear is dropped.
module mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpct_pkg::MOUSE_BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cursor_x, cursor_y, left_pressed, zero padding to bytes
    output logic [((2*COORD_BITS+8)/8)*8-1:0]   m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mpct_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mpct_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mpct_pkg::*;

    localparam int TDATA_W = ((2*COORD_BITS+8)/8)*8;
    localparam int PAD_W   = TDATA_W - 2*COORD_BITS - 1;
    localparam int SW      = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;
    localparam int VW      = COORD_BITS + 2;

    phase_t                    phase_reg, phase_next;
    logic                      left_reg;
    logic [MOUSE_BYTE_W-1:0]   xdelta_reg;
    logic [COORD_BITS-1:0]     pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic                      out_left_reg;
    logic                      m_valid_reg, m_valid_next;
    logic [CFG_DATA_W-1:0]     width_reg, height_reg;

    logic                      s_accept;
    logic                      header_load, xdelta_load, packet_done;
    logic [COORD_BITS-1:0]     hi_x, hi_y;

    function automatic logic [COORD_BITS-1:0] size_limit(input logic [CFG_DATA_W-1:0] size);
        logic [SW-1:0] ext;
        logic [SW-1:0] lim;
        logic [SW-1:0] cap_m1;
        ext    = SW'(size);
        cap_m1 = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
        lim    = (ext == '0) ? '0 : ext - 1'b1;
        if (lim > cap_m1) begin
            lim = cap_m1;
        end
        return lim[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_pos(input logic signed [VW-1:0] v,
                                                       input logic [COORD_BITS-1:0] hi);
        logic [COORD_BITS-1:0] res;
        if (v[VW-1]) begin
            res = '0;
        end else if (v[VW-2:0] > {1'b0, hi}) begin
            res = hi;
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (phase_reg == PH_HEADER) || (phase_reg == PH_XDELTA) ||
                      !m_valid_reg || m_tready;

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                if (s_accept && s_tdata[HDR_SYNC_IDX]) begin
                    phase_next = PH_XDELTA;
                end
            end
            PH_XDELTA: begin
                if (s_accept) begin
                    phase_next = PH_YDELTA;
                end
            end
            default: begin
                if (s_accept) begin
                    phase_next = PH_HEADER;
                end
            end
        endcase
    end

    always_comb begin
        header_load = 1'b0;
        xdelta_load = 1'b0;
        packet_done = 1'b0;
        unique case (phase_reg)
            PH_HEADER: header_load = s_accept && s_tdata[HDR_SYNC_IDX];
            PH_XDELTA: xdelta_load = s_accept;
            default:   packet_done = s_accept;
        endcase
    end

    assign hi_x = size_limit(width_reg);
    assign hi_y = size_limit(height_reg);

    always_comb begin
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        vx = $signed({2'b00, pos_x_reg}) + $signed({{(VW-8){xdelta_reg[7]}}, xdelta_reg});
        vy = $signed({2'b00, pos_y_reg}) - $signed({{(VW-8){s_tdata[7]}}, s_tdata});
        pos_x_next = clamp_pos(vx, hi_x);
        pos_y_next = clamp_pos(vy, hi_y);
    end

    assign m_valid_next = packet_done ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            m_valid_reg <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            width_reg   <= SCREEN_WIDTH_RST;
            height_reg  <= SCREEN_HEIGHT_RST;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (packet_done) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (cfg_wr_en && cfg_addr == CFG_SCREEN_WIDTH) begin
                width_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_addr == CFG_SCREEN_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (header_load) begin
            left_reg <= s_tdata[HDR_LEFT_IDX];
        end
        if (xdelta_load) begin
            xdelta_reg <= s_tdata;
        end
        if (packet_done) begin
            out_left_reg <= left_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_left_reg, pos_y_reg, pos_x_reg};

endmodule

// ===== rtl/mpct_checker.sv =====
// Port-level checks for the mouse packet cursor tracker, bound to the top level.
module mpct_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((2*COORD_BITS+8)/8)*8-1:0]  m_tdata
);

    // hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // drop any result on reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a fresh result follows an accepted byte
    a_new_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !($past(m_tvalid) && !$past(m_tready)) |-> $past(s_tvalid && s_tready))
        else $error("result without a completing byte");

    // take bytes whenever the output register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // keep the padding clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[((2*COORD_BITS+8)/8)*8-1:2*COORD_BITS+1] == '0)
        else $error("padding bits set");

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(
    .COORD_BITS (COORD_BITS)
) u_mpct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/mouse_packet_cursor_tracker_test.sv =====
`timescale 1ns / 100ps
// Testbench for the mouse packet cursor tracker: mouse bytes in, cursor reports checked out.
module mouse_packet_cursor_tracker_test;
    import mpct_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int M_TDATA_W       = ((2*COORD_BITS+8)/8)*8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = 4;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
    } cursor_report_t;

    typedef struct {
        logic [7:0]     data;
        bit             typed;
        cursor_report_t want;
    } directed_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [MOUSE_BYTE_W-1:0] s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = CFG_SCREEN_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // tracker state as seen from outside
    phase_t                tracker_phase = PH_HEADER;
    logic [7:0]            hdr_byte      = '0;
    logic [7:0]            xdelta_byte   = '0;
    logic [COORD_BITS-1:0] cur_x         = '0;
    logic [COORD_BITS-1:0] cur_y         = '0;
    logic [CFG_DATA_W-1:0] scr_w         = SCREEN_WIDTH_RST;
    logic [CFG_DATA_W-1:0] scr_h         = SCREEN_HEIGHT_RST;

    cursor_report_t expected_reports [$];
    int             counted_items  = 0;
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    int             send_idle_pct;
    int             recv_stall_pct;

    assign send_idle_pct  = (counted_items < 500) ? 18 : (counted_items < 1000) ? 46 : 0;
    assign recv_stall_pct = (counted_items < 500) ? 46 : (counted_items < 1000) ? 18 : 0;

    directed_row_t directed [23] = '{
        '{8'h00, 1'b0, '0},
        '{8'hF7, 1'b0, '0},
        '{8'h09, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h80, 1'b1, '{12'd127, 12'd128, 1'b1}},
        '{8'h08, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b1, '{12'd0, 12'd1, 1'b0}},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{12'd0, 12'd1, 1'b1}},
        '{8'h0E, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h01, 1'b1, '{12'd0, 12'd0, 1'b0}},
        '{8'h08, 1'b0, '0},
        '{8'h08, 1'b0, '0},
        '{8'hF8, 1'b1, '{12'd8, 12'd8, 1'b0}},
        '{8'h1D, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h3C, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h7F, 1'b0, '0}
    };

    logic [CFG_DATA_W-1:0] screen_sizes [6][2] = '{
        '{13'd0,    13'd0},
        '{13'd1,    13'd8191},
        '{13'd4096, 13'd4096},
        '{13'd8191, 13'd1},
        '{13'd4097, 13'd4095},
        '{13'd2,    13'd3}
    };

    mouse_packet_cursor_tracker #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [COORD_BITS-1:0] clamp_move(logic [COORD_BITS-1:0] pos, int delta,
                                                         logic [CFG_DATA_W-1:0] size);
        int lim;
        int v;
        lim = (size == 0) ? 1 : int'(size);
        if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
        v = int'(pos) + delta;
        if (v < 0) v = 0;
        if (v > lim - 1) v = lim - 1;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic bit advance_tracker(input logic [7:0] b, output cursor_report_t rep);
        rep = '0;
        case (tracker_phase)
            PH_HEADER: begin
                if (b[HDR_SYNC_IDX]) begin
                    hdr_byte      = b;
                    tracker_phase = PH_XDELTA;
                end
                return 1'b0;
            end
            PH_XDELTA: begin
                xdelta_byte   = b;
                tracker_phase = PH_YDELTA;
                return 1'b0;
            end
            default: begin
                tracker_phase = PH_HEADER;
                cur_x    = clamp_move(cur_x, int'($signed(xdelta_byte)), scr_w);
                cur_y    = clamp_move(cur_y, -int'($signed(b)), scr_h);
                rep.x    = cur_x;
                rep.y    = cur_y;
                rep.left = hdr_byte[HDR_LEFT_IDX];
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_delta(int dir);
        if ($urandom_range(1)) return 8'($urandom_range(255));
        if (dir > 0) return 8'($urandom_range(8'h7F, 8'h60));
        if (dir < 0) return 8'($urandom_range(8'h9F, 8'h80));
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            default: return 8'h80;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input cursor_report_t want);
        int             n_idle;
        cursor_report_t rep;
        n_idle = 0;
        while ($urandom_range(99) < send_idle_pct) n_idle++;
        if (n_idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (n_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        if (tracker_phase != PH_HEADER || b[HDR_SYNC_IDX]) counted_items++;
        if (advance_tracker(b, rep)) expected_reports.push_back(typed ? want : rep);
        @(posedge aclk);
    endtask

    task automatic set_screen(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr  <= CFG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    task automatic run_random_phase();
        int             start;
        int             push_x;
        int             push_y;
        int             roll;
        cursor_report_t none;
        none   = '0;
        start  = counted_items;
        push_x = int'($urandom_range(2)) - 1;
        push_y = int'($urandom_range(2)) - 1;
        while (counted_items - start < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_byte(8'($urandom_range(255) & 8'hF7), 1'b0, none);
            end else begin
                send_byte(8'($urandom_range(255) | 8'h08), 1'b0, none);
                send_byte(pick_delta(push_x), 1'b0, none);
                // drop the third byte now and then to break the framing
                if (roll >= 12) send_byte(pick_delta(push_y), 1'b0, none);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input cursor_report_t want,
                                   input cursor_report_t got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%s: expected x=%0d y=%0d left=%0d, got x=%0d y=%0d left=%0d",
                     what, want.x, want.y, want.left, got.x, got.y, got.left);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge aclk) begin : check_reports
        cursor_report_t got;
        cursor_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x    = m_tdata[COORD_BITS-1:0];
            got.y    = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.left = m_tdata[2*COORD_BITS];
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected beat", '0, got);
            end else begin
                want = expected_reports.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.left !== want.left)
                    report_mismatch("report mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("mouse_packet_cursor_tracker test failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 23; i++)
            send_byte(directed[i].data, directed[i].typed, directed[i].want);
        run_random_phase();
        for (int i = 0; i < 6; i++) begin
            set_screen(screen_sizes[i][0], screen_sizes[i][1]);
            run_random_phase();
        end
        set_screen(CFG_DATA_W'($urandom_range(4096, 1)), CFG_DATA_W'($urandom_range(4096, 1)));
        run_random_phase();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("mouse_packet_cursor_tracker test passed");
        end else begin
            $display("mouse_packet_cursor_tracker test failed");
        end
        $finish;
    end

endmodule
